// ===== hw/rtl/baro_pressure_temp_compensation_macros.svh =====
// Assertion macros shared by the checker of the barometric compensation block.
// Depends on nothing; included by the checker file only.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BPTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bptc: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define BPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bptc: next-cycle check failed");

`endif

// ===== hw/rtl/bptc_pkg.sv =====
// Types and constants of the barometric compensation block.
// Depends on nothing; used by the top level and its checker.
package bptc_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_TEMP_CAL  = 2'd0,
    CFG_PRESS_LOW = 2'd1,
    CFG_PRESS_MID = 2'd2,
    CFG_PRESS_HI  = 2'd3
  } cfg_idx_t;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 48;
  localparam int InDataW = 48;
  localparam int OutDataW = 40;

endpackage

// ===== hw/rtl/baro_pressure_temp_compensation.sv =====
// Barometric pressure and temperature compensation, thirteen-stage pipeline.
// Depends on bptc_pkg for register indexes and port widths.
//
//  channel | direction | payload                                   | handshake
//  in_     | slave     | tdata: raw_pressure, raw_temperature      | tvalid/tready
//  out_    | master    | tdata: temp_centi_celsius, pressure_pa_q6 | tvalid/tready
//          |           | tuser: out_of_range                       |
//  cfg_    | write     | cfg_index selects, cfg_wdata is the value | cfg_wen
//
// One beat enters per cycle while out_ is not stalled; each result passes through
// the stages of the multiplier chain (temperature quadratic, cube, pressure terms).
// Reset (synchronous, active low) clears the valid bits and the calibration.
// A stall on out_ freezes every stage at once and drops in_tready; nothing is
// lost or repeated, and the output register keeps its beat until taken.
module baro_pressure_temp_compensation #(
  parameter int PRESS_FRAC_BITS = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [bptc_pkg::InDataW-1:0]      in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] temp_centi_celsius, [39:16] pressure_pa_q6
  output logic [bptc_pkg::OutDataW-1:0]     out_tdata,
  // [0] out_of_range
  output logic                              out_tuser,
  input  logic                              cfg_wen,
  input  logic [bptc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [bptc_pkg::CfgDataW-1:0]     cfg_wdata
);

  localparam int NumStages = 13;
  localparam int AccW = 58;
  localparam int ShiftQ = 30 - PRESS_FRAC_BITS;
  localparam logic signed [AccW:0] RoundHalf = {{AccW{1'b0}}, 1'b1} << (ShiftQ - 1);

  // Calibration registers.
  logic [39:0] tcal_r;
  logic [47:0] pcl_r;
  logic [47:0] pcm_r;
  logic [31:0] pch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcal_r <= '0;
      pcl_r  <= '0;
      pcm_r  <= '0;
      pch_r  <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        bptc_pkg::CFG_TEMP_CAL:  tcal_r <= cfg_wdata[39:0];
        bptc_pkg::CFG_PRESS_LOW: pcl_r  <= cfg_wdata[47:0];
        bptc_pkg::CFG_PRESS_MID: pcm_r  <= cfg_wdata[47:0];
        bptc_pkg::CFG_PRESS_HI:  pch_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Calibration words as operands, all signed but for the unsigned t1.
  logic        [15:0] t1;
  logic signed [16:0] t2_s;
  logic signed [7:0]  t3_s;
  logic signed [16:0] p1m_s;
  logic signed [16:0] p2m_s;
  logic signed [7:0]  p3_s;
  logic signed [7:0]  p4_s;
  logic signed [16:0] p5_s;
  logic signed [16:0] p6_s;
  logic signed [7:0]  p7_s;
  logic signed [7:0]  p8_s;
  logic signed [15:0] p9_s;
  logic signed [7:0]  p10_s;
  logic signed [7:0]  p11_s;

  assign t1    = tcal_r[15:0];
  assign t2_s  = $signed({1'b0, tcal_r[31:16]});
  assign t3_s  = $signed(tcal_r[39:32]);
  assign p1m_s = $signed({pcl_r[15], pcl_r[15:0]}) - 17'sd16384;
  assign p2m_s = $signed({pcl_r[31], pcl_r[31:16]}) - 17'sd16384;
  assign p3_s  = $signed(pcl_r[39:32]);
  assign p4_s  = $signed(pcl_r[47:40]);
  assign p5_s  = $signed({1'b0, pcm_r[15:0]});
  assign p6_s  = $signed({1'b0, pcm_r[31:16]});
  assign p7_s  = $signed(pcm_r[39:32]);
  assign p8_s  = $signed(pcm_r[47:40]);
  assign p9_s  = $signed(pch_r[15:0]);
  assign p10_s = $signed(pch_r[23:16]);
  assign p11_s = $signed(pch_r[31:24]);

  // Pipeline advance: every stage moves together unless the output is stuck.
  logic                 en;
  logic [NumStages-1:0] vld_r;

  assign en         = !vld_r[NumStages-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[NumStages-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NumStages-2:0], in_tvalid};
    end
  end

  // Stage 1: offset of the raw temperature.
  logic signed [25:0] d_nxt;
  logic        [23:0] s1_p_r;
  logic signed [25:0] s1_d_r;

  assign d_nxt = $signed({2'b00, in_tdata[47:24]}) - $signed({2'b00, t1, 8'h00});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p_r <= in_tdata[23:0];
      s1_d_r <= d_nxt;
    end
  end

  // Stage 2: linear and square terms of the offset.
  logic        [23:0] s2_p_r;
  logic signed [42:0] s2_dt2_r;
  logic signed [51:0] s2_dd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p_r   <= s1_p_r;
      s2_dt2_r <= s1_d_r * t2_s;
      s2_dd_r  <= s1_d_r * s1_d_r;
    end
  end

  // Stage 3: square term times its coefficient.
  logic        [23:0] s3_p_r;
  logic signed [42:0] s3_dt2_r;
  logic signed [59:0] s3_ddt3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p_r    <= s2_p_r;
      s3_dt2_r  <= s2_dt2_r;
      s3_ddt3_r <= s2_dd_r * t3_s;
    end
  end

  // Stage 4: exact Q48 temperature, floored to Q24.
  logic signed [61:0] nt;
  logic        [23:0] s4_p_r;
  logic signed [37:0] s4_tf_r;

  assign nt = (62'(s3_dt2_r) <<< 18) + 62'(s3_ddt3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_p_r  <= s3_p_r;
      s4_tf_r <= nt[61:24];
    end
  end

  // Stage 5: scale to hundredths and clamp the temperature for the pressure path.
  logic signed [45:0] m_nxt;
  logic signed [31:0] tq_nxt;
  logic               tclamp;
  logic        [23:0] s5_p_r;
  logic signed [45:0] s5_m_r;
  logic signed [31:0] s5_tq_r;
  logic               s5_flag_r;

  assign m_nxt = s4_tf_r * 46'sd100;

  always_comb begin
    tclamp = 1'b0;
    tq_nxt = s4_tf_r[31:0];
    if (s4_tf_r > 38'sd2147483647) begin
      tq_nxt = 32'sh7FFF_FFFF;
      tclamp = 1'b1;
    end else if (s4_tf_r < -38'sd2147483648) begin
      tq_nxt = 32'sh8000_0000;
      tclamp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_p_r    <= s4_p_r;
      s5_m_r    <= m_nxt;
      s5_tq_r   <= tq_nxt;
      s5_flag_r <= tclamp;
    end
  end

  // Stage 6: temperature output, square of the temperature and of the pressure.
  logic signed [45:0] m_adj;
  logic signed [21:0] c22;
  logic signed [15:0] centi_nxt;
  logic               csat;
  logic        [23:0] s6_p_r;
  logic signed [31:0] s6_tq_r;
  logic signed [63:0] s6_tp2_r;
  logic        [47:0] s6_p2_r;
  logic signed [15:0] s6_centi_r;
  logic               s6_flag_r;

  // Truncation toward zero: bias negative values before the shift.
  assign m_adj = s5_m_r[45] ? (s5_m_r + 46'sd16777215) : s5_m_r;
  assign c22   = m_adj[45:24];

  always_comb begin
    csat      = 1'b0;
    centi_nxt = c22[15:0];
    if (c22 > 22'sd32767) begin
      centi_nxt = 16'sh7FFF;
      csat      = 1'b1;
    end else if (c22 < -22'sd32768) begin
      centi_nxt = 16'sh8000;
      csat      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_p_r     <= s5_p_r;
      s6_tq_r    <= s5_tq_r;
      s6_tp2_r   <= s5_tq_r * s5_tq_r;
      s6_p2_r    <= s5_p_r * s5_p_r;
      s6_centi_r <= centi_nxt;
      s6_flag_r  <= s5_flag_r | csat;
    end
  end

  // Stage 7: cube halves, products with the temperature and its square, squared pressure times p11.
  logic signed [71:0] p7t2_full;
  logic signed [71:0] p3t2_full;
  logic signed [39:0] p10tq;
  logic        [23:0] s7_p_r;
  logic        [47:0] s7_p2_r;
  logic signed [64:0] s7_tlo_r;
  logic signed [63:0] s7_thi_r;
  logic signed [45:0] s7_p7t2_r;
  logic signed [47:0] s7_p3t2_r;
  logic signed [48:0] s7_p6tq_r;
  logic signed [48:0] s7_p2tq_r;
  logic signed [40:0] s7_x_r;
  logic signed [56:0] s7_y_r;
  logic signed [15:0] s7_centi_r;
  logic               s7_flag_r;

  assign p7t2_full = p7_s * s6_tp2_r;
  assign p3t2_full = p3_s * s6_tp2_r;
  assign p10tq     = p10_s * s6_tq_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_p_r     <= s6_p_r;
      s7_p2_r    <= s6_p2_r;
      s7_tlo_r   <= $signed({1'b0, s6_tp2_r[31:0]}) * s6_tq_r;
      s7_thi_r   <= $signed(s6_tp2_r[63:32]) * s6_tq_r;
      s7_p7t2_r  <= p7t2_full[71:26];
      s7_p3t2_r  <= p3t2_full[71:24];
      s7_p6tq_r  <= p6_s * s6_tq_r;
      s7_p2tq_r  <= p2m_s * s6_tq_r;
      s7_x_r     <= (41'(p9_s) <<< 24) + 41'(p10tq);
      s7_y_r     <= $signed({1'b0, s6_p2_r}) * p11_s;
      s7_centi_r <= s6_centi_r;
      s7_flag_r  <= s6_flag_r;
    end
  end

  // Stage 8: finish the cube; split products of the squared pressure.
  logic        [23:0] s8_p_r;
  logic signed [63:0] s8_tp3_r;
  logic signed [65:0] s8_phx_r;
  logic signed [65:0] s8_plx_r;
  logic signed [53:0] s8_yhp_r;
  logic signed [53:0] s8_ylp_r;
  logic signed [45:0] s8_p7t2_r;
  logic signed [47:0] s8_p3t2_r;
  logic signed [48:0] s8_p6tq_r;
  logic signed [48:0] s8_p2tq_r;
  logic signed [15:0] s8_centi_r;
  logic               s8_flag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_p_r     <= s7_p_r;
      s8_tp3_r   <= s7_thi_r + 64'($signed(s7_tlo_r[64:32]));
      s8_phx_r   <= $signed({1'b0, s7_p2_r[47:24]}) * s7_x_r;
      s8_plx_r   <= $signed({1'b0, s7_p2_r[23:0]}) * s7_x_r;
      s8_yhp_r   <= $signed(s7_y_r[56:28]) * $signed({1'b0, s7_p_r});
      s8_ylp_r   <= $signed({1'b0, s7_y_r[27:0]}) * $signed({1'b0, s7_p_r});
      s8_p7t2_r  <= s7_p7t2_r;
      s8_p3t2_r  <= s7_p3t2_r;
      s8_p6tq_r  <= s7_p6tq_r;
      s8_p2tq_r  <= s7_p2tq_r;
      s8_centi_r <= s7_centi_r;
      s8_flag_r  <= s7_flag_r;
    end
  end

  // Stage 9: products with the cube; recombine the split pressure products.
  logic signed [71:0] p8t3_full;
  logic signed [71:0] p4t3_full;
  logic signed [90:0] h_full;
  logic signed [81:0] c_full;
  logic        [23:0] s9_p_r;
  logic signed [46:0] s9_p8t3_r;
  logic signed [50:0] s9_p4t3_r;
  logic signed [48:0] s9_hterm_r;
  logic signed [46:0] s9_cterm_r;
  logic signed [45:0] s9_p7t2_r;
  logic signed [47:0] s9_p3t2_r;
  logic signed [48:0] s9_p6tq_r;
  logic signed [48:0] s9_p2tq_r;
  logic signed [15:0] s9_centi_r;
  logic               s9_flag_r;

  assign p8t3_full = p8_s * s8_tp3_r;
  assign p4t3_full = p4_s * s8_tp3_r;
  assign h_full    = (91'(s8_phx_r) <<< 24) + 91'(s8_plx_r);
  assign c_full    = (82'(s8_yhp_r) <<< 28) + 82'(s8_ylp_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s9_p_r     <= s8_p_r;
      s9_p8t3_r  <= p8t3_full[71:25];
      s9_p4t3_r  <= p4t3_full[71:21];
      s9_hterm_r <= h_full[90:42];
      s9_cterm_r <= c_full[81:35];
      s9_p7t2_r  <= s8_p7t2_r;
      s9_p3t2_r  <= s8_p3t2_r;
      s9_p6tq_r  <= s8_p6tq_r;
      s9_p2tq_r  <= s8_p2tq_r;
      s9_centi_r <= s8_centi_r;
      s9_flag_r  <= s8_flag_r;
    end
  end

  // Stage 10: sensitivity sum (Q56) and offset sum (Q30).
  logic        [23:0] s10_p_r;
  logic signed [56:0] s10_s_r;
  logic signed [55:0] s10_off_r;
  logic signed [48:0] s10_hterm_r;
  logic signed [46:0] s10_cterm_r;
  logic signed [15:0] s10_centi_r;
  logic               s10_flag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_p_r     <= s9_p_r;
      s10_s_r     <= (57'(p1m_s) <<< 36) + (57'(s9_p2tq_r) <<< 3)
                   + 57'(s9_p3t2_r) + 57'(s9_p4t3_r);
      s10_off_r   <= (56'(p5_s) <<< 33) + 56'(s9_p6tq_r)
                   + 56'(s9_p7t2_r) + 56'(s9_p8t3_r);
      s10_hterm_r <= s9_hterm_r;
      s10_cterm_r <= s9_cterm_r;
      s10_centi_r <= s9_centi_r;
      s10_flag_r  <= s9_flag_r;
    end
  end

  // Stage 11: pressure times sensitivity in two halves; sum the other terms.
  logic signed [54:0] s11_psh_r;
  logic signed [52:0] s11_psl_r;
  logic signed [57:0] s11_hsum_r;
  logic signed [15:0] s11_centi_r;
  logic               s11_flag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s11_psh_r   <= $signed(s10_s_r[56:27]) * $signed({1'b0, s10_p_r});
      s11_psl_r   <= $signed({1'b0, s10_s_r[26:0]}) * $signed({1'b0, s10_p_r});
      s11_hsum_r  <= 58'(s10_off_r) + 58'(s10_hterm_r) + 58'(s10_cterm_r);
      s11_centi_r <= s10_centi_r;
      s11_flag_r  <= s10_flag_r;
    end
  end

  // Stage 12: full Q30 pressure accumulator.
  logic signed [AccW-1:0] s12_acc_r;
  logic signed [15:0]     s12_centi_r;
  logic                   s12_flag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s12_acc_r   <= s11_hsum_r + (AccW'(s11_psh_r) <<< 1)
                   + AccW'($signed({1'b0, s11_psl_r[52:26]}));
      s12_centi_r <= s11_centi_r;
      s12_flag_r  <= s11_flag_r;
    end
  end

  // Stage 13: round half up, saturate and hold the output beat.
  logic signed [AccW:0] rq;
  logic signed [AccW:0] qs;
  logic        [23:0]   q_nxt;
  logic                 qsat;
  logic        [23:0]   out_p_r;
  logic signed [15:0]   out_t_r;
  logic                 out_f_r;

  assign rq = (AccW + 1)'(s12_acc_r) + RoundHalf;
  assign qs = rq >>> ShiftQ;

  always_comb begin
    qsat  = 1'b0;
    q_nxt = qs[23:0];
    if (qs < 0) begin
      q_nxt = '0;
      qsat  = 1'b1;
    end else if (qs > (AccW + 1)'(24'hFF_FFFF)) begin
      q_nxt = 24'hFF_FFFF;
      qsat  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_p_r <= q_nxt;
      out_t_r <= s12_centi_r;
      out_f_r <= s12_flag_r | qsat;
    end
  end

  assign out_tdata = {out_p_r, out_t_r};
  assign out_tuser = out_f_r;

endmodule

// ===== hw/rtl/bptc_checker.sv =====
// Port-level checker for the barometric compensation block, bound to the top.
// Depends on bptc_pkg and the assertion macro header.
`include "baro_pressure_temp_compensation_macros.svh"

module bptc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [bptc_pkg::OutDataW-1:0] out_tdata,
  input logic                          out_tuser
);

  // A stalled output beat holds its payload.
  `BPTC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // An empty output stage always lets a new input beat in.
  `BPTC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)

  // A stalled output stage back-pressures the input.
  `BPTC_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, out_tvalid && !out_tready, !in_tready)

  // Right after reset the output stage is empty.
  `BPTC_ASSERT_NOW(a_empty_after_reset, clk, rst_n, !$past(rst_n), !out_tvalid)

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (.*);

// ===== test/tb_baro_pressure_temp_compensation.sv =====
// Self-checking testbench of the barometric pressure and temperature compensation block.
// Depends on bptc_pkg and baro_pressure_temp_compensation; a built-in predictor checks each beat.
`timescale 1ns / 100ps

module tb_baro_pressure_temp_compensation;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [15:0] temp_centi;
    logic        [23:0] press_q6;
    logic               range_flag;
  } comp_reading_t;

  localparam int PressFracBits = 6;
  localparam int AccFrac = 30;
  localparam int StallLimit = 5000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  // [23:0] raw_pressure, [47:24] raw_temperature
  logic [bptc_pkg::InDataW-1:0]  in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  // [15:0] temp_centi_celsius, [39:16] pressure_pa_q6
  logic [bptc_pkg::OutDataW-1:0] out_tdata;
  // [0] out_of_range
  logic                          out_tuser;
  logic                          cfg_wen;
  logic [bptc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [bptc_pkg::CfgDataW-1:0] cfg_wdata;

  // Calibration as the block should hold it.
  logic [39:0] cal_temp;
  logic [47:0] cal_press_low;
  logic [47:0] cal_press_mid;
  logic [31:0] cal_press_high;

  comp_reading_t pending_readings[$];
  int            fail_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            quiet_cycles;

  baro_pressure_temp_compensation #(.PRESS_FRAC_BITS(PressFracBits)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Fixed-point helpers: exact wide products, floored shifts, 64-bit saturation.
  function automatic longint clamp64(wide_t v);
    if (v > wide_t'(64'sh7FFF_FFFF_FFFF_FFFF)) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (v < -wide_t'(64'sh7FFF_FFFF_FFFF_FFFF) - 1) return 64'sh8000_0000_0000_0000;
    return longint'(v);
  endfunction

  function automatic longint floor_prod(longint a, longint b, int s);
    wide_t prod;
    prod = wide_t'(a) * wide_t'(b);
    return clamp64(prod >>> s);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    return clamp64(wide_t'(a) + wide_t'(b));
  endfunction

  // Computes the compensated reading for one raw pair under the current calibration.
  function automatic comp_reading_t compensate(logic [23:0] raw_p, logic [23:0] raw_t);
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint press, d, num, temp_q24, m, centi, tq, tq2, tq3, sens, acc, press_sq, q;
    comp_reading_t r;
    logic flag;
    t1 = longint'(cal_temp[15:0]);
    t2 = longint'(cal_temp[31:16]);
    t3 = longint'($signed(cal_temp[39:32]));
    p1 = longint'($signed(cal_press_low[15:0]));
    p2 = longint'($signed(cal_press_low[31:16]));
    p3 = longint'($signed(cal_press_low[39:32]));
    p4 = longint'($signed(cal_press_low[47:40]));
    p5 = longint'(cal_press_mid[15:0]);
    p6 = longint'(cal_press_mid[31:16]);
    p7 = longint'($signed(cal_press_mid[39:32]));
    p8 = longint'($signed(cal_press_mid[47:40]));
    p9 = longint'($signed(cal_press_high[15:0]));
    p10 = longint'($signed(cal_press_high[23:16]));
    p11 = longint'($signed(cal_press_high[31:24]));
    press = longint'(raw_p);
    flag = 1'b0;

    // Temperature quadratic, exact in Q48 then floored to Q24.
    d = longint'(raw_t) - t1 * 256;
    num = d * t2 * 262144 + d * d * t3;
    temp_q24 = floor_prod(num, 1, 24);

    // Centi-degrees, truncated toward zero and saturated.
    m = temp_q24 * 100;
    if (m < 0) centi = -((-m) >>> 24);
    else centi = m >>> 24;
    if (centi > 32767) begin
      centi = 32767;
      flag = 1'b1;
    end
    if (centi < -32768) begin
      centi = -32768;
      flag = 1'b1;
    end

    // Temperature seen by the pressure polynomial is clamped to +-128 degrees.
    tq = temp_q24;
    if (tq > 64'sd2147483647) begin
      tq = 64'sd2147483647;
      flag = 1'b1;
    end
    if (tq < -64'sd2147483648) begin
      tq = -64'sd2147483648;
      flag = 1'b1;
    end
    tq2 = tq * tq;
    tq3 = floor_prod(tq2, tq, 32);

    // Offset part in Q30.
    acc = p5 * (64'sd1 <<< 33);
    acc = sat_sum(acc, p6 * tq);
    acc = sat_sum(acc, floor_prod(p7, tq2, 26));
    acc = sat_sum(acc, floor_prod(p8, tq3, 25));

    // Sensitivity part in Q56, scaled by the raw pressure.
    sens = (p1 - 16384) * (64'sd1 <<< 36);
    sens = sat_sum(sens, (p2 - 16384) * tq * 8);
    sens = sat_sum(sens, floor_prod(p3, tq2, 24));
    sens = sat_sum(sens, floor_prod(p4, tq3, 21));
    acc = sat_sum(acc, floor_prod(press, sens, 26));

    // Square and cube terms of the raw pressure.
    press_sq = press * press;
    acc = sat_sum(acc, floor_prod(press_sq, p9 * (64'sd1 <<< 24) + p10 * tq, 42));
    acc = sat_sum(acc, floor_prod(press_sq * p11, press, 35));

    // Round half up to the output fraction and saturate.
    q = floor_prod(sat_sum(acc, 64'sd1 <<< (AccFrac - PressFracBits - 1)), 1,
                   AccFrac - PressFracBits);
    if (q < 0) begin
      q = 0;
      flag = 1'b1;
    end
    if (q > 16777215) begin
      q = 16777215;
      flag = 1'b1;
    end

    r.temp_centi = centi[15:0];
    r.press_q6 = q[23:0];
    r.range_flag = flag;
    return r;
  endfunction

  // Result side: random stalls and the in-order compare.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    comp_reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected beat tdata=%h tuser=%b", $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if ($signed(out_tdata[15:0]) !== want.temp_centi) begin
          $display("%0t: temperature expected %0d actual %0d", $time,
                   want.temp_centi, $signed(out_tdata[15:0]));
          fail_count++;
        end
        if (out_tdata[39:16] !== want.press_q6) begin
          $display("%0t: pressure expected %0d actual %0d", $time,
                   want.press_q6, out_tdata[39:16]);
          fail_count++;
        end
        if (out_tuser !== want.range_flag) begin
          $display("%0t: range flag expected %b actual %b", $time,
                   want.range_flag, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one raw reading and records its expected result on acceptance.
  task automatic send_reading(logic [23:0] raw_p, logic [23:0] raw_t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {raw_t, raw_p};
    do @(posedge clk); while (!in_tready);
    pending_readings.push_back(compensate(raw_p, raw_t));
  endtask

  // Waits until every expected beat is out and the pipeline has emptied.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Drives one register write; the caller drops the write enable afterwards.
  task automatic write_cal(bptc_pkg::cfg_idx_t idx, logic [47:0] value);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      bptc_pkg::CFG_TEMP_CAL:  cal_temp = value[39:0];
      bptc_pkg::CFG_PRESS_LOW: cal_press_low = value;
      bptc_pkg::CFG_PRESS_MID: cal_press_mid = value;
      bptc_pkg::CFG_PRESS_HI:  cal_press_high = value[31:0];
      default: ;
    endcase
  endtask

  task automatic load_cal(logic [39:0] tc, logic [47:0] pl, logic [47:0] pm, logic [31:0] ph);
    drain();
    write_cal(bptc_pkg::CFG_TEMP_CAL, {8'd0, tc});
    write_cal(bptc_pkg::CFG_PRESS_LOW, pl);
    write_cal(bptc_pkg::CFG_PRESS_MID, pm);
    write_cal(bptc_pkg::CFG_PRESS_HI, {16'd0, ph});
    cfg_wen <= 1'b0;
  endtask

  // Calibration close to what a real part carries, with random spread.
  task automatic load_typical_cal;
    logic [15:0] t1;
    t1 = 16'(27000 + $urandom_range(1500));
    load_cal({8'($urandom_range(255)), 16'(18500 + $urandom_range(1500)), t1},
             {8'($urandom_range(255)), 8'($urandom_range(255)),
              16'($urandom_range(65535)), 16'($urandom_range(65535))},
             {8'($urandom_range(255)), 8'($urandom_range(255)),
              16'($urandom_range(500)), 16'(23000 + $urandom_range(4000))},
             {8'($urandom_range(255)), 8'($urandom_range(255)),
              16'($urandom_range(65535))});
  endtask

  task automatic load_random_cal;
    load_cal({$urandom, 8'($urandom)}, {$urandom, 16'($urandom)},
             {$urandom, 16'($urandom)}, $urandom);
  endtask

  // Raw temperature mostly near the calibrated zero point, sometimes anywhere.
  function automatic logic [23:0] pick_raw_temp;
    int near;
    if ($urandom_range(9) < 7) begin
      near = int'(cal_temp[15:0]) * 256 + $urandom_range(800000) - 400000;
      if (near < 0) near = 0;
      if (near > 16777215) near = 16777215;
      return 24'(near);
    end
    return 24'($urandom);
  endfunction

  task automatic test_reset_calibration;
    send_reading(24'd0, 24'd0);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'h800000, 24'h000001);
  endtask

  task automatic test_directed_extremes;
    // Typical calibration: zero offset, extremes of both readings.
    load_cal({8'hF9, 16'd19000, 16'd27500}, {8'h02, 8'hF0, 16'hFFE0, 16'hFFF0},
             {8'hF8, 8'h03, 16'd60, 16'd25000}, {8'hFB, 8'h05, 16'h00F0});
    send_reading(24'd6500000, 24'd7040000);
    send_reading(24'd0, 24'd7040000);
    send_reading(24'hFFFFFF, 24'd7040000);
    send_reading(24'd6500000, 24'd0);
    send_reading(24'd6500000, 24'hFFFFFF);
    send_reading(24'd6400001, 24'd7200003);
    // Huge gain: the first reading drives the temperature far past the clamp, and both outputs saturate.
    load_cal({8'h7F, 16'hFFFF, 16'h0000}, 48'h7F7F_7FFF_7FFF, 48'h7F7F_FFFF_FFFF,
             32'h7F7F_7FFF);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'd0, 24'd0);
    send_reading(24'h123456, 24'h000100);
    // All-ones words: signed coefficients of -1, negative sums.
    load_cal(40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_reading(24'hFFFFFF, 24'hFFFFFF);
    send_reading(24'd0, 24'hFFFFFF);
    send_reading(24'hFFFFFF, 24'd0);
    // Most negative pressure coefficients with a cold reading.
    load_cal({8'h80, 16'hFFFF, 16'hFFFF}, 48'h8080_8000_8000, 48'h8080_0000_0000,
             32'h8080_8000);
    send_reading(24'hFFFFFF, 24'd0);
    send_reading(24'h000001, 24'h7FFFFF);
    // Offset only: result is exactly p5 scaled, checks rounding.
    load_cal(40'd0, {8'h00, 8'h00, 16'h4000, 16'h4000}, {8'h00, 8'h00, 16'h0000, 16'd12345},
             32'd0);
    send_reading(24'd0, 24'd0);
    send_reading(24'hFFFFFF, 24'd5);
  endtask

  task automatic test_random_readings(int n_items, int cal_blocks);
    for (int b = 0; b < cal_blocks; b++) begin
      if ($urandom_range(3) == 0) load_random_cal();
      else load_typical_cal();
      for (int i = 0; i < n_items / cal_blocks; i++) begin
        send_reading(($urandom_range(3) == 0) ? 24'($urandom) :
                     24'(5000000 + $urandom_range(3000000)), pick_raw_temp());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_wen = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cal_temp = '0;
    cal_press_low = '0;
    cal_press_mid = '0;
    cal_press_high = '0;
    fail_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 12;
    recv_idle_pct = 84;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_calibration();
    test_directed_extremes();
    test_random_readings(480, 6);
    send_idle_pct = 84;
    recv_idle_pct = 12;
    test_random_readings(480, 6);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_readings(480, 6);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bptc_pkg.sv
hw/rtl/baro_pressure_temp_compensation.sv
hw/rtl/bptc_checker.sv
test/tb_baro_pressure_temp_compensation.sv
